/* sv/chs_pkg.sv */
package chs_pkg;
    localparam int MAX_KNOTS_DEF = 64;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;
    localparam logic [1:0] OP_WRAP  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]   operation;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] yp;
    } chs_in_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]   status;
        logic signed [31:0] max_x;
    } chs_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic clear;
        logic add_write;  // write knot and coefficients
        logic fold_start;
        logic fold_step;
        logic fold_done;
        logic scan_rd;    // issue knot read at scan index
        logic scan_chk;   // check read data
        logic seg_rd;     // read previous knot and coefficients
        logic div_start;
        logic div_step;
        logic poly_step;
        logic [2:0] poly_phase;
        logic finish;     // build result
        logic [1:0] fin_status;
        logic fin_eval;   // value from polynomial
    } chs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic empty;
        logic full;
        logic fold_needed;
        logic fold_last;
        logic scan_hit;
        logic scan_end;
        logic scan_first;
        logic div_last;
    } chs_sts_t;
endpackage

/* sv/cubic_hermite_spline_table.sv */
// Cubic Hermite spline table, Q16.16. Operations: clear, add knot, evaluate and
// wrapped evaluate, one result per transfer. Clear and add finish at dispatch.
// After dispatch, an evaluation reads and compares one knot per scan step,
// then reads the segment, runs a serial division for t and the polynomial
// (mostly on a shared multiplier) and builds the output; a wrapped evaluation
// that folds first runs a serial remainder. The knot and coefficient stores
// hold no reset.
module cubic_hermite_spline_table
    import chs_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  chs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output chs_out_t m_data
);
    chs_cmd_t cmd;
    chs_sts_t sts;

    chs_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    chs_datapath #(.MAX_KNOTS(MAX_KNOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_data), .cmd(cmd),
        .sts(sts), .out_item(m_data)
    );
endmodule

/* sv/chs_datapath.sv */
module chs_datapath
    import chs_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  chs_in_t  in_item,
    input  chs_cmd_t cmd,
    output chs_sts_t sts,
    output chs_out_t out_item
);
    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW = $clog2(MAX_KNOTS + 1);

    logic [95:0]  knot_mem [MAX_KNOTS];
    logic [143:0] coef_mem [MAX_KNOTS];

    chs_in_t item_reg;
    logic [CW-1:0] count_reg, count_next;
    logic signed [31:0] last_x_reg;
    logic signed [31:0] q_reg;
    logic [CW-1:0] idx_reg;
    logic [95:0] knot_rd_reg;
    logic [143:0] coef_rd_reg;
    logic signed [31:0] prev_y_reg, prev_yp_reg;
    logic signed [31:0] bx_reg;

    // fold: |q| / |m| by restoring division, 32 steps
    logic [31:0] fq_reg, fm_reg;
    logic [32:0] frem_reg;
    logic [5:0]  fcnt_reg;
    // t division: 49-bit numerator by 33-bit den, 17 quotient bits needed
    logic [32:0] den_reg;
    logic [49:0] drem_reg;
    logic [16:0] t_reg;
    logic [5:0]  dcnt_reg;
    logic [48:0] num_sh;
    // polynomial
    logic signed [35:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [16:0] t2_reg, t3_reg;
    logic [33:0] sq_reg;
    logic signed [55:0] prod_reg;
    logic signed [57:0] acc_reg;
    chs_out_t out_reg;

    logic [35:0] mul_a;
    logic [16:0] mul_b;
    logic signed [55:0] mul_s;
    logic [33:0] mul_u;

    assign sts.op = item_reg.operation;
    assign sts.empty = (count_reg == '0);
    assign sts.full = (count_reg >= CW'(MAX_KNOTS));
    assign sts.fold_needed = (last_x_reg != 0) &&
        (item_reg.x < 0 || item_reg.x > last_x_reg);
    assign sts.fold_last = (fcnt_reg == 6'd31);
    assign sts.scan_hit = ($signed(knot_rd_reg[95:64]) >= q_reg);
    assign sts.scan_end = (idx_reg == count_reg);
    assign sts.scan_first = (idx_reg == '0);
    assign sts.div_last = (dcnt_reg == 6'd16);
    assign out_item = out_reg;

    logic [31:0] qabs;
    logic [32:0] frem_sh;
    logic [31:0] fold_r;
    always_comb begin
        qabs = item_reg.x[31] ? (~item_reg.x + 32'd1) : item_reg.x;
        frem_sh = {frem_reg[31:0], fq_reg[31]};
        fold_r = frem_reg[31:0];
    end

    // first step gives the integer bit, the next 16 the fraction
    logic [49:0] dsh;
    always_comb begin
        dsh = (dcnt_reg == 6'd0) ? drem_reg : {drem_reg[48:0], 1'b0};
        num_sh = {17'(0), 32'(q_reg - $signed(knot_rd_reg[95:64]))} << 16;
    end

    always_comb begin
        mul_a = '0;
        mul_b = t_reg;
        case (cmd.poly_phase)
            3'd0: begin mul_a = {19'd0, t_reg}; mul_b = t_reg; end
            3'd1: begin mul_a = {19'd0, t2_reg}; mul_b = t_reg; end
            3'd2: begin mul_a = cc_reg; mul_b = t_reg; end
            3'd3: begin mul_a = cb_reg; mul_b = t2_reg; end
            3'd4: begin mul_a = ca_reg; mul_b = t3_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_s = $signed(mul_a) * $signed({1'b0, mul_b});
        mul_u = mul_a[16:0] * mul_b;
    end

    logic signed [57:0] acc_fl;
    always_comb acc_fl = acc_reg >>> 16;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            last_x_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.clear) last_x_reg <= '0;
            if (cmd.add_write) last_x_reg <= item_reg.x;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) count_next = '0;
        if (cmd.add_write) count_next = count_reg + CW'(1);
    end

    logic [AW-1:0] wr_a, prv_a;
    always_comb begin
        wr_a = count_reg[AW-1:0];
        prv_a = AW'(idx_reg - CW'(1));
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_write) begin
            knot_mem[wr_a] <= {item_reg.x, item_reg.y, item_reg.yp};
            if (count_reg != '0) begin
                coef_mem[AW'(count_reg - CW'(1))] <= {
                    36'(2*36'(signed'(prev_y_reg)) + 36'(signed'(prev_yp_reg))
                        - 2*36'(signed'(item_reg.y)) + 36'(signed'(item_reg.yp))),
                    36'(-3*36'(signed'(prev_y_reg)) - 2*36'(signed'(prev_yp_reg))
                        + 3*36'(signed'(item_reg.y)) - 36'(signed'(item_reg.yp))),
                    36'(signed'(prev_yp_reg)), 36'(signed'(prev_y_reg))};
            end
        end
        if (cmd.scan_rd) knot_rd_reg <= knot_mem[idx_reg[AW-1:0]];
        if (cmd.seg_rd) begin
            knot_rd_reg <= knot_mem[prv_a];
            coef_rd_reg <= coef_mem[prv_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
            idx_reg <= '0;
        end
        if (cmd.add_write) begin
            prev_y_reg <= item_reg.y;
            prev_yp_reg <= item_reg.yp;
        end
        if (cmd.load) q_reg <= in_item.x;
        if (cmd.fold_start) begin
            fq_reg <= qabs;
            fm_reg <= last_x_reg[31] ? (~last_x_reg + 32'd1) : last_x_reg;
            frem_reg <= '0;
            fcnt_reg <= '0;
        end
        if (cmd.fold_step) begin
            fq_reg <= {fq_reg[30:0], 1'b0};
            fcnt_reg <= fcnt_reg + 6'd1;
            if (frem_sh >= {1'b0, fm_reg}) frem_reg <= frem_sh - {1'b0, fm_reg};
            else frem_reg <= frem_sh;
        end
        if (cmd.fold_done) q_reg <= item_reg.x[31] ? (~fold_r + 32'd1) : fold_r;
        if (cmd.scan_chk && !sts.scan_hit) idx_reg <= idx_reg + CW'(1);
        if (cmd.scan_chk) bx_reg <= knot_rd_reg[95:64];
        if (cmd.div_start) begin
            den_reg <= 33'(bx_reg - $signed(knot_rd_reg[95:64]));
            drem_reg <= {1'b0, num_sh} >> 16;
            dcnt_reg <= '0;
            t_reg <= '0;
            {ca_reg, cb_reg, cc_reg, cd_reg} <= coef_rd_reg;
        end
        if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (dsh >= {17'd0, den_reg}) begin
                drem_reg <= dsh - {17'd0, den_reg};
                t_reg <= {t_reg[15:0], 1'b1};
            end else begin
                drem_reg <= dsh;
                t_reg <= {t_reg[15:0], 1'b0};
            end
        end
        if (cmd.poly_step) begin
            case (cmd.poly_phase)
                3'd0: sq_reg <= mul_u;
                3'd1: begin
                    t2_reg <= sq_reg[32:16];
                    sq_reg <= 34'(sq_reg[32:16] * t_reg);
                    acc_reg <= 58'(cd_reg) <<< 16;
                end
                3'd2: begin
                    t3_reg <= sq_reg[32:16];
                    prod_reg <= mul_s;
                end
                3'd3: begin
                    acc_reg <= acc_reg + 58'(prod_reg);
                    prod_reg <= mul_s;
                end
                3'd4: begin
                    acc_reg <= acc_reg + 58'(prod_reg);
                    prod_reg <= mul_s;
                end
                3'd5: acc_reg <= acc_reg + 58'(prod_reg);
                default: ;
            endcase
        end
        if (cmd.finish) begin
            out_reg.status <= cmd.fin_status;
            out_reg.max_x <= (cmd.clear) ? 32'sd0 :
                (cmd.add_write ? item_reg.x : last_x_reg);
            if (!cmd.fin_eval) out_reg.value <= '0;
            else if (acc_fl > 58'sh7FFFFFFF) out_reg.value <= 32'sh7FFFFFFF;
            else if (acc_fl < -58'sh80000000) out_reg.value <= 32'sh80000000;
            else out_reg.value <= acc_fl[31:0];
        end
    end
endmodule

/* sv/chs_controller.sv */
module chs_controller
    import chs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  chs_sts_t sts,
    output chs_cmd_t cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_FOLD = 4'd2,
        S_FOLDE = 4'd3, S_RD = 4'd4, S_CHK = 4'd5, S_SEG = 4'd6, S_DIVI = 4'd7,
        S_DIV = 4'd8, S_POLY = 4'd9, S_OUT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [2:0] ph_reg, ph_next;
    logic busy_reg, busy_next;
    logic mv_reg, mv_next;

    assign s_ready = !busy_reg && (!mv_reg || m_ready);
    assign m_valid = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ph_reg <= '0;
            busy_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg <= ph_next;
            busy_reg <= busy_next;
            mv_reg <= mv_next;
        end
    end

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        ph_next = ph_reg;
        busy_next = busy_reg;
        mv_next = mv_reg && !m_ready;
        cmd.poly_phase = ph_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    busy_next = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (sts.op)
                    OP_CLEAR: begin
                        cmd.clear = 1'b1; cmd.finish = 1'b1; cmd.fin_status = ST_OK;
                        state_next = S_OUT;
                    end
                    OP_ADD: begin
                        cmd.finish = 1'b1;
                        cmd.fin_status = sts.full ? ST_FULL : ST_OK;
                        cmd.add_write = !sts.full;
                        state_next = S_OUT;
                    end
                    default: begin
                        if (sts.empty) begin
                            cmd.finish = 1'b1; cmd.fin_status = ST_EMPTY;
                            state_next = S_OUT;
                        end else if (sts.op == OP_WRAP && sts.fold_needed) begin
                            cmd.fold_start = 1'b1;
                            state_next = S_FOLD;
                        end else state_next = S_RD;
                    end
                endcase
            end
            S_FOLD: begin
                cmd.fold_step = 1'b1;
                if (sts.fold_last) state_next = S_FOLDE;
            end
            S_FOLDE: begin
                cmd.fold_done = 1'b1;
                state_next = S_RD;
            end
            S_RD: begin
                if (sts.scan_end) begin
                    cmd.finish = 1'b1; cmd.fin_status = ST_OUTSIDE;
                    state_next = S_OUT;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                cmd.scan_chk = 1'b1;
                if (!sts.scan_hit) state_next = S_RD;
                else if (sts.scan_first) begin
                    cmd.finish = 1'b1; cmd.fin_status = ST_OUTSIDE;
                    state_next = S_OUT;
                end else state_next = S_SEG;
            end
            S_SEG: begin
                cmd.seg_rd = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI: begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    ph_next = '0;
                    state_next = S_POLY;
                end
            end
            S_POLY: begin
                if (ph_reg == 3'd6) begin
                    cmd.finish = 1'b1; cmd.fin_status = ST_OK; cmd.fin_eval = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.poly_step = 1'b1;
                    ph_next = ph_reg + 3'd1;
                end
            end
            S_OUT: begin
                mv_next = 1'b1;
                busy_next = 1'b0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* sv/chs_checker.sv */
module chs_checker
    import chs_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input chs_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input chs_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_noacc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer accepted during work");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |-> m_data.value == 0 && m_data.max_x == 0)
        else $error("empty table result not zero");
    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_OUTSIDE || m_data.status == ST_FULL)
            |-> m_data.value == 0)
        else $error("nonzero value with error status");
endmodule

bind cubic_hermite_spline_table chs_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

/* sim/cubic_hermite_spline_table_tb.sv */
module cubic_hermite_spline_table_tb;
    import chs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKNOTS = MAX_KNOTS_DEF;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int LONG_STALL_CYCLES = 3000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    chs_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    chs_out_t m_data;

    cubic_hermite_spline_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // spline state mirror
    logic signed [31:0] kx [NKNOTS];
    logic signed [31:0] ky [NKNOTS];
    logic signed [31:0] kyp[NKNOTS];
    logic signed [63:0] ca [NKNOTS];
    logic signed [63:0] cb [NKNOTS];
    logic signed [63:0] cc [NKNOTS];
    logic signed [63:0] cd [NKNOTS];
    int knots_held = 0;

    chs_in_t  pending_items[$];
    chs_out_t expected_results[$];
    int  errors = 0;
    int  cycles = 0;
    bit  hold_sender = 1'b0;
    bit  long_stall = 1'b0;
    bit  long_done = 1'b0;
    int  accepted_cnt = 0;
    int  popped_cnt = 0;

    function automatic logic signed [31:0] last_knot_x();
        return knots_held == 0 ? 32'sd0 : kx[knots_held-1];
    endfunction

    function automatic logic signed [63:0] floor_q16(logic signed [127:0] v);
        logic signed [127:0] s;
        s = v >>> 16;
        if (s > 128'sh7fffffff) return 64'sh7fffffff;
        if (s < -128'sh80000000) return -64'sh80000000;
        return s[63:0];
    endfunction

    function automatic chs_out_t apply_spline_op(chs_in_t it);
        chs_out_t r;
        logic signed [63:0] q, m, num, den, t, t2, t3;
        logic signed [127:0] acc;
        int i;
        r = '0;
        r.status = ST_OK;
        case (it.operation)
            OP_CLEAR: knots_held = 0;
            OP_ADD: begin
                if (knots_held >= NKNOTS) begin
                    r.status = ST_FULL;
                end else begin
                    kx[knots_held] = it.x;
                    ky[knots_held] = it.y;
                    kyp[knots_held] = it.yp;
                    if (knots_held > 0) begin
                        i = knots_held - 1;
                        ca[i] = 2*64'(ky[i]) + kyp[i] - 2*64'(it.y) + it.yp;
                        cb[i] = -3*64'(ky[i]) - 2*64'(kyp[i]) + 3*64'(it.y) - it.yp;
                        cc[i] = 64'(kyp[i]);
                        cd[i] = 64'(ky[i]);
                    end
                    knots_held++;
                end
            end
            default: begin
                q = 64'(it.x);
                if (it.operation == OP_WRAP) begin
                    m = 64'(last_knot_x());
                    if ((q < 0 || q > m) && m != 0) q = q % m;
                end
                if (knots_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (i = 0; i < knots_held; i++)
                        if (kx[i] >= q) break;
                    if (i == 0 || i == knots_held) begin
                        r.status = ST_OUTSIDE;
                    end else begin
                        num = q - kx[i-1];
                        den = 64'(kx[i]) - kx[i-1];
                        t = (num <<< 16) / den;
                        t2 = (t * t) >>> 16;
                        t3 = (t2 * t) >>> 16;
                        acc = 128'(cd[i-1]) * 65536 + 128'(cc[i-1]) * t
                            + 128'(cb[i-1]) * t2 + 128'(ca[i-1]) * t3;
                        r.value = 32'(floor_q16(acc));
                    end
                end
            end
        endcase
        r.max_x = last_knot_x();
        return r;
    endfunction

    // driver: bursts and gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && popped_cnt == accepted_cnt)) begin
            if (popped_cnt != accepted_cnt) begin
                void'(pending_items.pop_front());
                popped_cnt++;
            end
            if (pending_items.size() == 0 || hold_sender) begin
                s_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data <= pending_items[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
                end
            end
        end
    end

    always @(posedge aclk)
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(apply_spline_op(s_data));
            accepted_cnt++;
        end

    int stall_mode = 0;
    int long_cnt = 0;
    always @(negedge aclk) begin
        if (long_stall && !long_done) begin
            m_ready <= 1'b0;
            long_cnt++;
            if (long_cnt >= LONG_STALL_CYCLES) long_done = 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        chs_out_t e;
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: %h", m_data);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_data.value !== e.value) begin
                    $error("value: expected %0d, actual %0d", e.value, m_data.value);
                    errors++;
                end
                if (m_data.status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_data.status);
                    errors++;
                end
                if (m_data.max_x !== e.max_x) begin
                    $error("max_x: expected %0d, actual %0d", e.max_x, m_data.max_x);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic chs_in_t mk(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] yp);
        chs_in_t it;
        it.operation = op;
        it.x = x;
        it.y = y;
        it.yp = yp;
        return it;
    endfunction

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65535 * 4) - 65536 * 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic push_table(int n, int step_max);
        int xp;
        xp = $signed($urandom_range(0, 400000)) - 200000;
        for (int k = 0; k < n; k++) begin
            pending_items.push_back(mk(OP_ADD, xp, rnd_val(), rnd_val()));
            xp += $urandom_range(1, step_max);
        end
    endtask

    initial begin
        int n, sent;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        pending_items.push_back(mk(OP_EVAL, 0, 0, 0));
        pending_items.push_back(mk(OP_WRAP, 32'h80000000, 0, 0));
        pending_items.push_back(mk(OP_ADD, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
        pending_items.push_back(mk(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h80000000));
        pending_items.push_back(mk(OP_EVAL, 32'h80000000, 0, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h7fffffff, 0, 0));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h80000001, 0, 0));
        pending_items.push_back(mk(OP_WRAP, 32'hffffffff, 0, 0));
        pending_items.push_back(mk(OP_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        pending_items.push_back(mk(OP_ADD, 0, 0, 32'h00010000));
        pending_items.push_back(mk(OP_ADD, 32'h00020000, 32'h00050000, 32'hfffe0000));
        pending_items.push_back(mk(OP_ADD, 32'h00010000, 32'h00010000, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h00008000, 0, 0));
        pending_items.push_back(mk(OP_EVAL, 32'h00020000, 0, 0));
        pending_items.push_back(mk(OP_WRAP, 32'h00050000, 0, 0));
        pending_items.push_back(mk(OP_WRAP, 32'hfffd0000, 0, 0));
        pending_items.push_back(mk(OP_CLEAR, 0, 0, 0));
        pending_items.push_back(mk(OP_ADD, 0, 0, 0));
        pending_items.push_back(mk(OP_WRAP, 32'h12345678, 0, 0));
        push_table(NKNOTS, 70000);
        pending_items.push_back(mk(OP_ADD, 1, 2, 3));
        pending_items.push_back(mk(OP_EVAL, 32'h00100000, 0, 0));
        wait_drained();

        // receiver holds off while the sender keeps offering
        long_stall = 1'b1;
        for (int k = 0; k < 20; k++)
            pending_items.push_back(mk(OP_EVAL, $urandom_range(0, 1 << 22), 0, 0));
        wait (long_done);
        long_stall = 1'b0;
        wait_drained();

        sent = 0;
        while (sent < 1790) begin
            pending_items.push_back(mk(OP_CLEAR, rnd_val(), rnd_val(), rnd_val()));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(NKNOTS - 2, NKNOTS + 2)
                                            : $urandom_range(0, 8);
            if ($urandom_range(0, 4) == 0) begin
                for (int k = 0; k < n; k++)
                    pending_items.push_back(mk(OP_ADD, rnd_val(), rnd_val(), rnd_val()));
            end else begin
                push_table(n, ($urandom_range(0, 1)) ? 200000 : 1 << 22);
            end
            sent += n + 1;
            for (int k = 0; k < 12; k++) begin
                if ($urandom_range(0, 7) == 0)
                    pending_items.push_back(mk(2'($urandom_range(0, 3)), rnd_val(),
                                               rnd_val(), rnd_val()));
                else
                    pending_items.push_back(mk($urandom_range(0, 1) ? OP_EVAL : OP_WRAP,
                                               rnd_val(), rnd_val(), rnd_val()));
                sent++;
            end
            if ($urandom_range(0, 15) == 0) begin
                hold_sender = 1'b1;
                while (expected_results.size() != 0 || s_valid) @(posedge aclk);
                hold_sender = 1'b0;
            end
            while (pending_items.size() > 200) @(posedge aclk);
        end
        wait_drained();
        repeat (500) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* files.f */
sv/chs_pkg.sv
sv/chs_datapath.sv
sv/chs_controller.sv
sv/cubic_hermite_spline_table.sv
sv/chs_checker.sv
sim/cubic_hermite_spline_table_tb.sv
